>>> design/crpw_pkg.sv
package crpw_pkg;

	// Largest rectangle side; larger requested sizes saturate to this.
	localparam int MaxDim = 4096;

	// Field widths fixed by the interface.
	localparam int CoordW  = 12;
	localparam int DimW    = 13;
	localparam int OffsetW = 24;
	localparam int PixelW  = 32;
	localparam int CfgIdxW = 2;

	// Configuration register reset values.
	localparam logic [DimW-1:0] FrameWidthRst  = DimW'(1024);
	localparam logic [DimW-1:0] FrameHeightRst = DimW'(768);
	localparam logic [DimW-1:0] RowStrideRst   = DimW'(1024);

	// Command codes of an input transaction.
	typedef enum logic [1:0] {
		CMD_FILL = 2'd0,
		CMD_BLIT = 2'd1,
		CMD_STEP = 2'd2
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ROW_STRIDE   = 2'd2,
		REG_DISP_ENABLE  = 2'd3
	} reg_idx_t;

	// Current configuration as seen by the datapath.
	typedef struct packed {
		logic [DimW-1:0] frame_width;
		logic [DimW-1:0] frame_height;
		logic [DimW-1:0] row_stride;
		logic            display_enable;
	} cfg_t;

	// One pixel write result.
	typedef struct packed {
		logic               write_enable;
		logic [OffsetW-1:0] word_offset;
		logic [PixelW-1:0]  write_data;
		logic               done_res;
	} result_t;

endpackage

>>> design/crpw_cfg_regs.sv
module crpw_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [crpw_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [crpw_pkg::DimW-1:0]      cfg_data,
	output crpw_pkg::cfg_t                 cfg
);

	crpw_pkg::cfg_t cfg_q;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	// Register file update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width    <= crpw_pkg::FrameWidthRst;
			cfg_q.frame_height   <= crpw_pkg::FrameHeightRst;
			cfg_q.row_stride     <= crpw_pkg::RowStrideRst;
			cfg_q.display_enable <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crpw_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width    <= cfg_data;
				crpw_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height   <= cfg_data;
				crpw_pkg::REG_ROW_STRIDE:   cfg_q.row_stride     <= cfg_data;
				crpw_pkg::REG_DISP_ENABLE:  cfg_q.display_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/crpw_walker.sv
module crpw_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [1:0]                    cmd,
	input  logic [crpw_pkg::CoordW-1:0]   origin_x,
	input  logic [crpw_pkg::CoordW-1:0]   origin_y,
	input  logic [crpw_pkg::DimW-1:0]     rect_width,
	input  logic [crpw_pkg::DimW-1:0]     rect_height,
	input  logic [crpw_pkg::PixelW-1:0]   pixel_value,
	input  crpw_pkg::cfg_t                cfg,
	output logic                          res_valid,
	output crpw_pkg::result_t             res
);

	localparam int DimW = crpw_pkg::DimW;
	localparam logic [DimW:0] MaxDimW = (DimW+1)'(crpw_pkg::MaxDim);

	logic                         busy_q;
	logic                         blit_mode_q;
	logic [crpw_pkg::CoordW-1:0]  start_x_q;
	logic [DimW-1:0]              size_w_q;
	logic [DimW-1:0]              size_h_q;
	logic [DimW-1:0]              cur_row_q;
	logic [DimW-1:0]              cur_col_q;
	logic [DimW-1:0]              abs_y_q;
	logic [crpw_pkg::PixelW-1:0]  fill_colour_q;

	logic [DimW-1:0]              w_clamped;
	logic [DimW-1:0]              h_clamped;
	logic [DimW-1:0]              col_next;
	logic [DimW-1:0]              row_next;
	logic [DimW-1:0]              pos_x;
	logic                         row_end;
	logic                         last_pos;
	logic                         we;
	logic [2*DimW-1:0]            product;
	logic [crpw_pkg::PixelW-1:0]  data;
	logic                         is_start;
	logic                         is_step;

	// Saturate requested sizes to the largest supported side.
	assign w_clamped = ({1'b0, rect_width} > MaxDimW) ? DimW'(MaxDimW) : rect_width;
	assign h_clamped = ({1'b0, rect_height} > MaxDimW) ? DimW'(MaxDimW) : rect_height;

	assign is_start = (cmd == crpw_pkg::CMD_FILL) || (cmd == crpw_pkg::CMD_BLIT);
	assign is_step  = (cmd == crpw_pkg::CMD_STEP) && busy_q;

	// Position of the current step and end-of-row / end-of-rectangle tests.
	assign col_next = cur_col_q + DimW'(1);
	assign row_next = cur_row_q + DimW'(1);
	assign pos_x    = DimW'({1'b0, start_x_q}) + cur_col_q;
	assign row_end  = (col_next == size_w_q);
	assign last_pos = row_end && (row_next == size_h_q);

	// Clip against the frame and form the word offset.
	assign we = cfg.display_enable && (pos_x < cfg.frame_width) && (abs_y_q < cfg.frame_height);
	assign product = (2*DimW)'(abs_y_q) * (2*DimW)'(cfg.row_stride);
	assign data = blit_mode_q ? pixel_value : fill_colour_q;

	always_comb begin
		res_valid        = accept && is_step;
		res.write_enable = we;
		res.word_offset  = we ? (product[crpw_pkg::OffsetW-1:0]
			+ crpw_pkg::OffsetW'(pos_x)) : '0;
		res.write_data   = we ? data : '0;
		res.done_res     = last_pos;
	end

	// Rectangle state: loaded by a start, advanced by each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			blit_mode_q   <= 1'b0;
			start_x_q     <= '0;
			size_w_q      <= '0;
			size_h_q      <= '0;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			abs_y_q       <= '0;
			fill_colour_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				blit_mode_q <= (cmd == crpw_pkg::CMD_BLIT);
				start_x_q   <= origin_x;
				abs_y_q     <= DimW'(origin_y);
				size_w_q    <= w_clamped;
				size_h_q    <= h_clamped;
				cur_row_q   <= '0;
				cur_col_q   <= '0;
				busy_q      <= (w_clamped != '0) && (h_clamped != '0);
				if (cmd == crpw_pkg::CMD_FILL) begin
					fill_colour_q <= pixel_value;
				end
			end else if (is_step) begin
				if (last_pos) begin
					busy_q    <= 1'b0;
					cur_col_q <= '0;
					cur_row_q <= '0;
				end else if (row_end) begin
					cur_col_q <= '0;
					cur_row_q <= row_next;
					abs_y_q   <= abs_y_q + DimW'(1);
				end else begin
					cur_col_q <= col_next;
				end
			end
		end
	end

endmodule

>>> design/crpw_out_buf.sv
module crpw_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  crpw_pkg::result_t  push_data,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output crpw_pkg::result_t  out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	crpw_pkg::result_t out_data_q;
	crpw_pkg::result_t skid_data_q;
	logic              pop;

	assign pop = out_valid_q && !out_stall;

	// Two-entry output buffer; the skid entry absorbs one transaction
	// while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload moves without reset.
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				if (push) begin
					skid_data_q <= push_data;
				end
			end else if (push) begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/clipped_rect_pixel_writer.sv
// Clipped rectangle pixel writer.
// Input channel (in_valid / in_stall): a start fill or start blit command
// latches the rectangle and produces no output; each step command visits
// the next position in row-major order and produces one output transaction.
// Output channel (out_valid / out_stall): write_enable, word_offset,
// write_data and done_res for one position; clipped positions come out with
// write_enable low and zero offset and data, and done_res marks the last one.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): frame
// width, frame height, row stride and display enable; cfg_ready is always
// high and writes belong in idle periods.
// One transaction is accepted every cycle while in_stall is low; steps with
// no active rectangle are ignored. The per-step path is one 13x13 multiply
// and add between the rectangle state and the output register. A two-entry
// output buffer lets the input run on while the receiver stalls; in_stall
// rises only when both entries are occupied. Reset clears the engine to
// idle, empties the buffer and restores the registers to 1024 x 768,
// stride 1024, display disabled.
module clipped_rect_pixel_writer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    cmd,
	input  logic [crpw_pkg::CoordW-1:0]   origin_x,
	input  logic [crpw_pkg::CoordW-1:0]   origin_y,
	input  logic [crpw_pkg::DimW-1:0]     rect_width,
	input  logic [crpw_pkg::DimW-1:0]     rect_height,
	input  logic [crpw_pkg::PixelW-1:0]   pixel_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_enable,
	output logic [crpw_pkg::OffsetW-1:0]  word_offset,
	output logic [crpw_pkg::PixelW-1:0]   write_data,
	output logic                          done_res,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [crpw_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [crpw_pkg::DimW-1:0]     cfg_data
);

	crpw_pkg::cfg_t    cfg;
	crpw_pkg::result_t res;
	crpw_pkg::result_t out_data;
	logic              res_valid;
	logic              accept;

	assign accept = in_valid && !in_stall;

	// Configuration registers.
	crpw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Rectangle walker and per-position result.
	crpw_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.pixel_value (pixel_value),
		.cfg         (cfg),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Output register with skid entry.
	crpw_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign write_enable = out_data.write_enable;
	assign word_offset  = out_data.word_offset;
	assign write_data   = out_data.write_data;
	assign done_res     = out_data.done_res;

endmodule

>>> test/clipped_rect_pixel_writer_tb.sv
`timescale 1ns / 1ps

module clipped_rect_pixel_writer_tb;
	import crpw_pkg::*;

	// Command code that the engine ignores.
	localparam logic [1:0] CmdUnused = 2'd3;
	// Cycles without any accepted transaction before the run is declared hung.
	localparam int unsigned WatchdogLimit = 2000;
	// Live commands per random phase, and number of random phases.
	localparam int unsigned PhaseItems = 250;
	localparam int unsigned PhaseCount = 7;

	// One input transaction.
	typedef struct packed {
		logic [1:0]        cmd;
		logic [CoordW-1:0] ox;
		logic [CoordW-1:0] oy;
		logic [DimW-1:0]   w;
		logic [DimW-1:0]   h;
		logic [PixelW-1:0] pix;
	} pixel_cmd_t;

	// One row of the directed plan: either a register set or a command,
	// optionally with a hand-written expected write.
	typedef struct packed {
		logic       is_cfg;
		cfg_t       cfg;
		pixel_cmd_t item;
		logic       typed;
		result_t    res;
	} plan_row_t;

	// Rectangle walk state of the engine.
	typedef struct packed {
		logic              busy;
		logic              blit;
		logic [CoordW-1:0] start_x;
		logic [DimW-1:0]   size_w;
		logic [DimW-1:0]   size_h;
		logic [DimW-1:0]   cur_row;
		logic [DimW-1:0]   cur_col;
		logic [DimW-1:0]   abs_y;
		logic [PixelW-1:0] colour;
	} rect_walk_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          cmd;
	logic [CoordW-1:0]   origin_x;
	logic [CoordW-1:0]   origin_y;
	logic [DimW-1:0]     rect_width;
	logic [DimW-1:0]     rect_height;
	logic [PixelW-1:0]   pixel_value;
	logic                out_valid;
	logic                out_stall;
	logic                write_enable;
	logic [OffsetW-1:0]  word_offset;
	logic [PixelW-1:0]   write_data;
	logic                done_res;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [DimW-1:0]     cfg_data;

	rect_walk_t    walk;
	cfg_t          frame_cfg;
	result_t       expected_writes[$];
	result_t       oldest_write;
	plan_row_t     directed_plan[$];
	int unsigned   mismatch_count;
	int unsigned   live_items;
	int unsigned   quiet_cycles;
	int unsigned   send_gap_pct;
	int unsigned   stall_pct;

	clipped_rect_pixel_writer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.origin_x(origin_x),
		.origin_y(origin_y),
		.rect_width(rect_width),
		.rect_height(rect_height),
		.pixel_value(pixel_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.write_enable(write_enable),
		.word_offset(word_offset),
		.write_data(write_data),
		.done_res(done_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the pixel write caused by one command and advances the walk.
	// Returns 1 when the command produces a write transaction.
	function automatic bit predict_pixel_write(input pixel_cmd_t c, output result_t r);
		logic [DimW-1:0]   x;
		logic [31:0]       offset;
		logic [PixelW-1:0] data;
		logic              we;
		logic              last;
		r = '0;
		if (c.cmd == CMD_FILL || c.cmd == CMD_BLIT) begin
			walk.blit = (c.cmd == CMD_BLIT);
			walk.start_x = c.ox;
			walk.abs_y = DimW'(c.oy);
			walk.size_w = (c.w > MaxDim) ? DimW'(MaxDim) : c.w;
			walk.size_h = (c.h > MaxDim) ? DimW'(MaxDim) : c.h;
			if (c.cmd == CMD_FILL) begin
				walk.colour = c.pix;
			end
			walk.cur_row = '0;
			walk.cur_col = '0;
			walk.busy = (walk.size_w != 0) && (walk.size_h != 0);
			return 1'b0;
		end
		if (c.cmd != CMD_STEP || !walk.busy) begin
			return 1'b0;
		end
		x = DimW'(walk.start_x) + walk.cur_col;
		data = walk.blit ? c.pix : walk.colour;
		we = frame_cfg.display_enable && (x < frame_cfg.frame_width)
			&& (walk.abs_y < frame_cfg.frame_height);
		offset = 32'(walk.abs_y) * 32'(frame_cfg.row_stride) + 32'(x);
		last = (32'(walk.cur_col) + 1 == 32'(walk.size_w))
			&& (32'(walk.cur_row) + 1 == 32'(walk.size_h));
		r.write_enable = we;
		r.word_offset = we ? offset[OffsetW-1:0] : '0;
		r.write_data = we ? data : '0;
		r.done_res = last;
		if (last) begin
			walk.busy = 1'b0;
			walk.cur_col = '0;
			walk.cur_row = '0;
		end else if (32'(walk.cur_col) + 1 == 32'(walk.size_w)) begin
			walk.cur_col = '0;
			walk.cur_row = walk.cur_row + 1'b1;
			walk.abs_y = walk.abs_y + 1'b1;
		end else begin
			walk.cur_col = walk.cur_col + 1'b1;
		end
		return 1'b1;
	endfunction

	// Directed plan builders.
	function automatic void add_item(input logic [1:0] c, input int unsigned ox,
			input int unsigned oy, input int unsigned w, input int unsigned h,
			input logic [PixelW-1:0] pix);
		plan_row_t row;
		row = '0;
		row.item = '{cmd: c, ox: CoordW'(ox), oy: CoordW'(oy), w: DimW'(w),
			h: DimW'(h), pix: pix};
		directed_plan.push_back(row);
	endfunction

	function automatic void add_result(input logic we, input int unsigned offset,
			input logic [PixelW-1:0] data, input logic last);
		directed_plan[$].typed = 1'b1;
		directed_plan[$].res = '{write_enable: we, word_offset: OffsetW'(offset),
			write_data: data, done_res: last};
	endfunction

	function automatic void add_config(input int unsigned w, input int unsigned h,
			input int unsigned stride, input logic en);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg = '{frame_width: DimW'(w), frame_height: DimW'(h),
			row_stride: DimW'(stride), display_enable: en};
		directed_plan.push_back(row);
	endfunction

	function automatic pixel_cmd_t random_cmd();
		pixel_cmd_t c;
		c.cmd = 2'($urandom_range(3));
		c.ox = CoordW'($urandom);
		c.oy = CoordW'($urandom);
		c.w = DimW'($urandom);
		c.h = DimW'($urandom);
		c.pix = $urandom;
		return c;
	endfunction

	// Origin close to a frame edge half of the time, anywhere otherwise.
	function automatic logic [CoordW-1:0] near_edge(input logic [DimW-1:0] limit);
		int v;
		if ($urandom_range(1) == 0) begin
			return CoordW'($urandom);
		end
		v = int'(limit) + int'($urandom_range(8)) - 6;
		if (v < 0) begin
			v = 0;
		end
		if (v > 4095) begin
			v = 4095;
		end
		return CoordW'(v);
	endfunction

	// Sends one command on the input channel. Entered and left at a rising edge.
	task automatic send_cmd(input pixel_cmd_t c, input logic typed, input result_t typed_res);
		bit      taken;
		bit      writes;
		result_t res;
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c.cmd;
		origin_x <= c.ox;
		origin_y <= c.oy;
		rect_width <= c.w;
		rect_height <= c.h;
		pixel_value <= c.pix;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		if (c.cmd == CMD_FILL || c.cmd == CMD_BLIT || (c.cmd == CMD_STEP && walk.busy)) begin
			live_items++;
		end
		writes = predict_pixel_write(c, res);
		if (writes) begin
			expected_writes.push_back(typed ? typed_res : res);
		end
	endtask

	// Lowers valid and waits until every expected write has come out.
	task automatic wait_drained(input int unsigned extra);
		in_valid <= 1'b0;
		while (expected_writes.size() != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [DimW-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		case (idx)
			REG_FRAME_WIDTH: frame_cfg.frame_width = val;
			REG_FRAME_HEIGHT: frame_cfg.frame_height = val;
			REG_ROW_STRIDE: frame_cfg.row_stride = val;
			REG_DISP_ENABLE: frame_cfg.display_enable = val[0];
			default: ;
		endcase
	endtask

	// Register writes happen only once the engine has gone quiet; a start
	// gives no write, so the wait runs on past the last expected write.
	task automatic apply_config(input cfg_t c);
		wait_drained(4);
		write_reg(REG_FRAME_WIDTH, c.frame_width);
		write_reg(REG_FRAME_HEIGHT, c.frame_height);
		write_reg(REG_ROW_STRIDE, c.row_stride);
		write_reg(REG_DISP_ENABLE, DimW'(c.display_enable));
		cfg_valid <= 1'b0;
	endtask

	// One random sequence: mostly a start followed by the steps that walk
	// its rectangle, sometimes noise, an empty or an abandoned rectangle.
	task automatic send_random_rect();
		pixel_cmd_t  c;
		pixel_cmd_t  s;
		int unsigned steps;
		c = random_cmd();
		if ($urandom_range(99) < 6) begin
			send_cmd(c, 1'b0, '0);
			return;
		end
		c.cmd = ($urandom_range(1) != 0) ? CMD_BLIT : CMD_FILL;
		c.ox = near_edge(frame_cfg.frame_width);
		c.oy = near_edge(frame_cfg.frame_height);
		if ($urandom_range(99) < 5) begin
			// Oversize or arbitrary request, left after a few steps.
			steps = $urandom_range(1, 8);
		end else begin
			c.w = DimW'($urandom_range(1, ($urandom_range(9) == 0) ? 24 : 5));
			c.h = DimW'($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 4));
			steps = c.w * c.h;
			if ($urandom_range(99) < 8) begin
				steps = $urandom_range(0, steps - 1);
			end
			if ($urandom_range(99) < 3) begin
				c.h = '0;
				steps = $urandom_range(0, 2);
			end
		end
		send_cmd(c, 1'b0, '0);
		repeat (steps) begin
			s = random_cmd();
			s.cmd = CMD_STEP;
			send_cmd(s, 1'b0, '0);
		end
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
			mismatch_count++;
		end
	endtask

	// Check each write transaction against the oldest expected one.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_writes.size() == 0) begin
				$display("%0t: write expected none, got we=%b offset=%h data=%h done=%b",
					$time, write_enable, word_offset, write_data, done_res);
				mismatch_count++;
			end else begin
				oldest_write = expected_writes.pop_front();
				compare_field("write_enable", 32'(oldest_write.write_enable),
					32'(write_enable));
				compare_field("word_offset", 32'(oldest_write.word_offset),
					32'(word_offset));
				compare_field("write_data", oldest_write.write_data, write_data);
				compare_field("done_res", 32'(oldest_write.done_res), 32'(done_res));
			end
		end
	end

	// Random receiver stalls.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	// Watchdog on cycles with no transaction on any channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= WatchdogLimit) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		cfg_t        phase_cfg;
		pixel_cmd_t  closer;
		int unsigned phase_start;
		bit          paused;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_FILL;
		origin_x <= '0;
		origin_y <= '0;
		rect_width <= '0;
		rect_height <= '0;
		pixel_value <= '0;
		out_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data <= '0;
		mismatch_count = 0;
		live_items = 0;
		quiet_cycles = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		walk = '0;
		frame_cfg = '{frame_width: FrameWidthRst, frame_height: FrameHeightRst,
			row_stride: RowStrideRst, display_enable: 1'b0};

		// Reset state: idle steps and the unused code do nothing, and a
		// disabled display suppresses the write but still finishes.
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_item(CmdUnused, 4095, 4095, 8191, 8191, 32'hFFFFFFFF);
		add_item(CMD_FILL, 0, 0, 1, 1, 32'hFFFFFFFF);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b0, 0, 32'h0, 1'b1);
		add_config(1024, 768, 1024, 1'b1);
		add_item(CMD_FILL, 0, 0, 1, 1, 32'hA5A5A5A5);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b1, 0, 32'hA5A5A5A5, 1'b1);
		// Bottom right corner of the frame: only the first position lands.
		add_item(CMD_FILL, 1023, 767, 2, 2, 32'h12345678);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b1, 767 * 1024 + 1023, 32'h12345678, 1'b0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b0, 0, 32'h0, 1'b0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b0, 0, 32'h0, 1'b0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b0, 0, 32'h0, 1'b1);
		// Empty rectangle, then a saturated one abandoned by an empty start.
		add_item(CMD_BLIT, 4095, 4095, 8191, 0, 32'h0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'hFFFFFFFF);
		add_item(CMD_BLIT, 4095, 4095, 8191, 8191, 32'h0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'hFFFFFFFF);
		add_result(1'b0, 0, 32'h0, 1'b0);
		add_item(CMD_FILL, 0, 0, 0, 4096, 32'h0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		// Blit takes the source pixel of each step.
		add_item(CMD_BLIT, 2, 3, 2, 1, 32'h0);
		add_item(CMD_STEP, 4095, 4095, 8191, 8191, 32'hDEADBEEF);
		add_result(1'b1, 3 * 1024 + 2, 32'hDEADBEEF, 1'b0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b1, 3 * 1024 + 3, 32'h0, 1'b1);
		add_item(CMD_BLIT, 0, 0, 4097, 1, 32'h0);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h5555AAAA);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'hAAAA5555);
		// Largest frame: the last word of the framebuffer.
		add_config(4096, 4096, 4096, 1'b1);
		add_item(CMD_FILL, 4095, 4095, 1, 1, 32'hFFFFFFFF);
		add_item(CMD_STEP, 0, 0, 0, 0, 32'h0);
		add_result(1'b1, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].is_cfg) begin
				apply_config(directed_plan[i].cfg);
			end else begin
				send_cmd(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].res);
			end
		end

		// Random phases, each with its own frame setup and idling pattern.
		for (int unsigned p = 0; p < PhaseCount; p++) begin
			case (p)
				0: phase_cfg = '{frame_width: 13'd1024, frame_height: 13'd768,
					row_stride: 13'd1024, display_enable: 1'b1};
				1: phase_cfg = '{frame_width: 13'd0, frame_height: 13'd0,
					row_stride: 13'd0, display_enable: 1'b1};
				2: phase_cfg = '{frame_width: 13'd4096, frame_height: 13'd4096,
					row_stride: 13'd4096, display_enable: 1'b1};
				3: phase_cfg = '{frame_width: 13'd4096, frame_height: 13'd4096,
					row_stride: 13'd4096, display_enable: 1'b0};
				default: phase_cfg = '{frame_width: DimW'($urandom_range(0, 48)),
					frame_height: DimW'($urandom_range(0, 48)),
					row_stride: DimW'($urandom_range(0, 4096)), display_enable: 1'b1};
			endcase
			apply_config(phase_cfg);
			case (p % 4)
				0: begin
					send_gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_gap_pct = 52;
					stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct = 52;
				end
				default: begin
					send_gap_pct = 36;
					stall_pct = 36;
				end
			endcase
			phase_start = live_items;
			paused = 1'b0;
			while (live_items - phase_start < PhaseItems) begin
				send_random_rect();
				// Halfway through, hold the input until the output side catches up.
				if (!paused && live_items - phase_start >= PhaseItems / 2) begin
					wait_drained(1);
					paused = 1'b1;
				end
			end
			// An empty start leaves the engine idle before the next register set.
			closer = random_cmd();
			closer.cmd = CMD_FILL;
			closer.w = '0;
			send_cmd(closer, 1'b0, '0);
		end

		wait_drained(8);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
